@@ src/rav_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rav_pkg
// Shared types and constants of the row averager.
// ----------------------------------------------------------------------------
package rav_pkg;

   localparam int MAX_ROW       = 256;
   localparam int POS_BITS      = $clog2(MAX_ROW);
   localparam int LEN_BITS      = 9;
   localparam int NROW_BITS     = 8;
   localparam int SAMPLE_BITS   = 16;
   localparam int SUM_BITS      = 24;
   localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);
   localparam int ROW_LENGTH_RESET = 144;

   localparam logic CSR_ROW_LENGTH      = 1'b0;
   localparam logic CSR_ROWS_TO_AVERAGE = 1'b1;

   typedef struct packed {
      logic [LEN_BITS-1:0]  row_length;
      logic [NROW_BITS-1:0] rows_to_average;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [POS_BITS-1:0]           pos;
      logic                          final_row;
      logic                          last_pos;
      logic [NROW_BITS-1:0]          nrows;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_DIV,
      BK_EMIT
   } back_state_type;

endpackage
`default_nettype wire

@@ src/rav_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rav_front
// Tracks row position and row count, tags each sample with its position,
// last-position and final-row flags.
// ----------------------------------------------------------------------------
module rav_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rav_pkg::cfg_type cfg,
   input  wire logic             accept,
   input  wire logic signed [rav_pkg::SAMPLE_BITS-1:0] sample,
   output rav_pkg::cmd_type      cmd
);

   logic [rav_pkg::POS_BITS-1:0]  position_ff, position_in;
   logic [rav_pkg::NROW_BITS-1:0] rows_done_ff, rows_done_in;
   logic [rav_pkg::LEN_BITS-1:0]  len;
   logic [rav_pkg::NROW_BITS-1:0] nrows;
   logic                          last_pos;
   logic                          final_row;

   always_comb begin
      priority if (cfg.row_length == '0) begin
         len = rav_pkg::LEN_BITS'(1);
      end else if (cfg.row_length > rav_pkg::LEN_BITS'(rav_pkg::MAX_ROW)) begin
         len = rav_pkg::LEN_BITS'(rav_pkg::MAX_ROW);
      end else begin
         len = cfg.row_length;
      end
      nrows = (cfg.rows_to_average == '0) ? rav_pkg::NROW_BITS'(1) : cfg.rows_to_average;
      last_pos  = ({1'b0, position_ff} >= (len - rav_pkg::LEN_BITS'(1)));
      final_row = (rows_done_ff >= (nrows - rav_pkg::NROW_BITS'(1)));
   end

   always_comb begin
      position_in  = position_ff;
      rows_done_in = rows_done_ff;
      if (accept) begin
         if (last_pos) begin
            position_in  = '0;
            rows_done_in = final_row ? '0 : rows_done_ff + rav_pkg::NROW_BITS'(1);
         end else begin
            position_in = position_ff + rav_pkg::POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         rows_done_ff <= '0;
      end else begin
         position_ff  <= position_in;
         rows_done_ff <= rows_done_in;
      end
   end

   assign cmd.sample    = sample;
   assign cmd.pos       = position_ff;
   assign cmd.final_row = final_row;
   assign cmd.last_pos  = last_pos;
   assign cmd.nrows     = nrows;

endmodule
`default_nettype wire

@@ src/rav_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rav_queue
// Four-entry command queue between front and back.
// ----------------------------------------------------------------------------
module rav_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire rav_pkg::cmd_type wr_cmd,
   output logic                  full,
   input  wire logic             rd_en,
   output rav_pkg::cmd_type      rd_cmd,
   output logic                  empty
);

   rav_pkg::cmd_type entry_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;

   assign full   = (count_ff == 3'd4);
   assign empty  = (count_ff == 3'd0);
   assign rd_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + {2'b0, wr_en} - {2'b0, rd_en};
      end
   end

endmodule
`default_nettype wire

@@ src/rav_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rav_back
// Accumulator read-modify-write, serial divide on the final row, and the
// result register.
// ----------------------------------------------------------------------------
module rav_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rav_pkg::cmd_type q_cmd,
   input  wire logic             q_empty,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic signed [rav_pkg::SAMPLE_BITS-1:0] rsp_average,
   output logic                  rsp_row_end
);

   localparam int SB = rav_pkg::SUM_BITS;
   localparam int NB = rav_pkg::NROW_BITS;
   localparam int WB = rav_pkg::SAMPLE_BITS;

   rav_pkg::back_state_type state_ff, state_in;
   rav_pkg::cmd_type        cmd_ff, cmd_in;

   logic [SB-1:0]           mem [rav_pkg::MAX_ROW];
   logic [rav_pkg::MAX_ROW-1:0] vld_ff;
   logic [SB-1:0]           rd_data_ff;
   logic                    rd_vld_ff;

   logic [SB-1:0]           quo_ff, quo_in;
   logic [NB-1:0]           rem_ff, rem_in;
   logic                    neg_ff, neg_in;
   logic [rav_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;

   logic                    out_vld_ff, out_vld_in;
   logic [WB-1:0]           out_avg_ff, out_avg_in;
   logic                    out_end_ff, out_end_in;

   logic [SB-1:0]           sum;
   logic [NB:0]             trial;
   logic                    take;
   logic                    mem_wr;
   logic                    vld_clr;
   logic                    can_load;
   logic [WB-1:0]           sat_val;

   assign sum   = (rd_vld_ff ? rd_data_ff : '0) + {{(SB-WB){cmd_ff.sample[WB-1]}}, cmd_ff.sample};
   assign trial = {rem_ff, quo_ff[SB-1]};
   assign take  = (trial >= {1'b0, cmd_ff.nrows});
   assign can_load = !out_vld_ff || rsp_pop;

   // saturate the signed quotient to the sample range
   always_comb begin
      if (neg_ff) begin
         if (quo_ff > SB'(32'd1 << (WB-1))) begin
            sat_val = {1'b1, {(WB-1){1'b0}}};
         end else begin
            sat_val = WB'(~quo_ff + SB'(1));
         end
      end else begin
         if (quo_ff > SB'((32'd1 << (WB-1)) - 32'd1)) begin
            sat_val = {1'b0, {(WB-1){1'b1}}};
         end else begin
            sat_val = quo_ff[WB-1:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rav_pkg::BK_IDLE: if (!q_empty) state_in = rav_pkg::BK_READ;
         rav_pkg::BK_READ: state_in = cmd_ff.final_row ? rav_pkg::BK_DIV : rav_pkg::BK_IDLE;
         rav_pkg::BK_DIV:  if (cnt_ff == '0) state_in = rav_pkg::BK_EMIT;
         rav_pkg::BK_EMIT: if (can_load) state_in = rav_pkg::BK_IDLE;
         default:          state_in = rav_pkg::BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      q_pop      = 1'b0;
      mem_wr     = 1'b0;
      vld_clr    = 1'b0;
      cmd_in     = cmd_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      neg_in     = neg_ff;
      cnt_in     = cnt_ff;
      out_vld_in = out_vld_ff && !rsp_pop;
      out_avg_in = out_avg_ff;
      out_end_in = out_end_ff;
      unique case (state_ff)
         rav_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
            end
         end
         rav_pkg::BK_READ: begin
            if (cmd_ff.final_row) begin
               vld_clr = 1'b1;
               neg_in  = sum[SB-1];
               quo_in  = sum[SB-1] ? (~sum + SB'(1)) : sum;
               rem_in  = '0;
               cnt_in  = rav_pkg::DIV_CNT_BITS'(SB - 1);
            end else begin
               mem_wr = 1'b1;
            end
         end
         rav_pkg::BK_DIV: begin
            rem_in = take ? NB'(trial - {1'b0, cmd_ff.nrows}) : trial[NB-1:0];
            quo_in = {quo_ff[SB-2:0], take};
            cnt_in = cnt_ff - rav_pkg::DIV_CNT_BITS'(1);
         end
         rav_pkg::BK_EMIT: begin
            if (can_load) begin
               out_vld_in = 1'b1;
               out_avg_in = sat_val;
               out_end_in = cmd_ff.last_pos;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_data_ff <= mem[q_cmd.pos];
         rd_vld_ff  <= vld_ff[q_cmd.pos];
      end
      if (mem_wr) begin
         mem[cmd_ff.pos] <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rav_pkg::BK_IDLE;
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         if (mem_wr)  vld_ff[cmd_ff.pos] <= 1'b1;
         if (vld_clr) vld_ff[cmd_ff.pos] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
      cnt_ff     <= cnt_in;
      out_avg_ff <= out_avg_in;
      out_end_ff <= out_end_in;
   end

   assign rsp_empty   = !out_vld_ff;
   assign rsp_average = out_avg_ff;
   assign rsp_row_end = out_end_ff;

   a_read_after_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == rav_pkg::BK_READ |-> $past(state_ff) == rav_pkg::BK_IDLE)
      else $error("read stage entered without a queue pop");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      state_ff == rav_pkg::BK_DIV |-> rem_ff < cmd_ff.nrows)
      else $error("divider remainder not below divisor");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == rav_pkg::BK_EMIT && can_load |=> out_vld_ff)
      else $error("result not loaded on emit");

endmodule
`default_nettype wire

@@ src/row_averager_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// row_averager_core
// Position-wise average of a window of rows of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: present a sample on req_sample with req_push; the word is
//    taken when req_full is low. The front tags it and drops it into a
//    four-entry queue.
//  - Result channel: while rsp_empty is low, rsp_average/rsp_row_end hold the
//    oldest result; pop it with rsp_pop. One result per sample of the final
//    row of each window; other samples give none.
//  - CSR channel: csr_index 0 = row_length, 1 = rows_to_average; csr_ready
//    is always high. Write only while idle.
//  - Back-end steps: the back end works on one sample at a time. A sample of a
//    summing row takes an accumulator read, then add and write back; a sample
//    of the final row takes a read, a 24-step serial divider and a result
//    load, and the serial divider is the longest of these steps.
//  - Path from accept to result on a final-row sample: queue, accumulator
//    read, serial divider, result register, plus any queue wait.
//  - Reset: position and row count clear, the accumulators read as zero via
//    per-entry valid bits (no clearing pass), config returns to 144 and 1.
//  - Receiver stall: the result register holds, the back end waits in its
//    emit step, the queue fills, then req_full rises.
// ----------------------------------------------------------------------------
module row_averager_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic signed [15:0] req_sample,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic signed [15:0] rsp_average,
   output logic             rsp_row_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [8:0]  csr_data
);

   rav_pkg::cfg_type cfg_ff;
   rav_pkg::cmd_type front_cmd;
   rav_pkg::cmd_type q_cmd;
   logic             accept;
   logic             q_empty;
   logic             q_pop;

   // hold configuration; any write completes at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_length      <= rav_pkg::LEN_BITS'(rav_pkg::ROW_LENGTH_RESET);
         cfg_ff.rows_to_average <= rav_pkg::NROW_BITS'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            rav_pkg::CSR_ROW_LENGTH:      cfg_ff.row_length      <= csr_data;
            rav_pkg::CSR_ROWS_TO_AVERAGE: cfg_ff.rows_to_average <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // take a word whenever the queue has room
   assign accept = req_push && !req_full;

   rav_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .sample (req_sample),
      .cmd    (front_cmd)
   );

   rav_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (accept),
      .wr_cmd (front_cmd),
      .full   (req_full),
      .rd_en  (q_pop),
      .rd_cmd (q_cmd),
      .empty  (q_empty)
   );

   rav_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_cmd       (q_cmd),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_average (rsp_average),
      .rsp_row_end (rsp_row_end)
   );

endmodule
`default_nettype wire
